// ===== src/itp_pkg.sv =====
// Shared types, codes and helper functions of the infix-to-postfix converter.
package itp_pkg;

    localparam logic [2:0] ACT_OPERAND  = 3'd0;
    localparam logic [2:0] ACT_OPERATOR = 3'd1;
    localparam logic [2:0] ACT_FUNCTION = 3'd2;
    localparam logic [2:0] ACT_OPEN     = 3'd3;
    localparam logic [2:0] ACT_CLOSE    = 3'd4;
    localparam logic [2:0] ACT_END      = 3'd5;

    localparam logic [1:0] KIND_OPERAND  = 2'd0;
    localparam logic [1:0] KIND_OPERATOR = 2'd1;
    localparam logic [1:0] KIND_FUNCTION = 2'd2;
    localparam logic [1:0] KIND_END      = 2'd3;

    localparam logic [1:0] ENT_PAREN = 2'd0;
    localparam logic [1:0] ENT_OP    = 2'd1;
    localparam logic [1:0] ENT_FUNC  = 2'd2;

    localparam logic [1:0] FAULT_NONE     = 2'd0;
    localparam logic [1:0] FAULT_CLOSE    = 2'd1;
    localparam logic [1:0] FAULT_OPEN     = 2'd2;
    localparam logic [1:0] FAULT_OVERFLOW = 2'd3;

    localparam logic [3:0] OP_MINUS  = 4'd1;
    localparam logic [3:0] OP_POW    = 4'd4;
    localparam logic [3:0] OP_MAX    = 4'd5;
    localparam logic [3:0] FUNC_MAX  = 4'd13;

    localparam int ENTRY_W = 6;

    typedef struct packed {
        logic [2:0]  action;
        logic [3:0]  code;
        logic [63:0] operand_word;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [3:0]  out_code;
        logic [63:0] out_operand;
        logic [1:0]  fault;
        logic        last;
    } t_out_item;

    function automatic logic [1:0] prec_of(input logic [ENTRY_W-1:0] entry);
        logic [1:0] p;
        if (entry[5:4] != ENT_OP) begin
            p = 2'd0;
        end else if (entry[3:0] <= OP_MINUS) begin
            p = 2'd1;
        end else if (entry[3:0] == OP_POW) begin
            p = 2'd3;
        end else begin
            p = 2'd2;
        end
        return p;
    endfunction

    function automatic t_out_item entry_item(input logic [ENTRY_W-1:0] entry);
        t_out_item r;
        r.out_kind    = entry[5:4];
        r.out_code    = entry[3:0];
        r.out_operand = 64'd0;
        r.fault       = FAULT_NONE;
        r.last        = 1'b0;
        return r;
    endfunction

    function automatic t_out_item marker_item(input logic [1:0] kind, input logic [1:0] flt);
        t_out_item r;
        r.out_kind    = kind;
        r.out_code    = 4'd0;
        r.out_operand = 64'd0;
        r.fault       = flt;
        r.last        = 1'b0;
        return r;
    endfunction

endpackage

// ===== src/itp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module itp_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/infix_to_postfix_converter_unit.sv =====
// Top level of the infix-to-postfix converter: stack sequencer, stack RAM and output stage.
// An operand passes through the token registers, the hold register and the output register.
// Each token is accepted, then decoded; each popped entry is emitted (parentheses excepted),
// then the new top is reloaded from the stack RAM, and a closing step ends the token.
// The next token is accepted once the previous one has handed over its final result.
// Reset clears the stack count, the sequencer and the output stage; stack RAM contents
// are not cleared, since no entry is used before it is written.
module infix_to_postfix_converter_unit #(
    parameter int STACK_DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  itp_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output itp_pkg::t_out_item o_out_data
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [1:0] {S_IDLE, S_WORK, S_LOAD, S_FIN} t_state;
    typedef enum logic [1:0] {PH_SEARCH, PH_CHECK, PH_DONE} t_phase;

    t_state                        r_state, n_state;
    t_phase                        r_phase, n_phase;
    logic [2:0]                    r_act, n_act;
    logic [3:0]                    r_code, n_code;
    logic [63:0]                   r_word, n_word;
    logic [CW-1:0]                 r_count, n_count;
    logic [itp_pkg::ENTRY_W-1:0]   r_top, n_top;
    logic [1:0]                    r_endflt, n_endflt;
    logic                          r_hold_v, n_hold_v;
    itp_pkg::t_out_item            r_hold, n_hold;
    logic                          r_ov, n_ov;
    itp_pkg::t_out_item            r_out, n_out;

    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic [AW-1:0]                 mem_raddr;
    logic [itp_pkg::ENTRY_W-1:0]   mem_rdata;
    logic [itp_pkg::ENTRY_W-1:0]   cur_entry;

    logic                          can_emit;
    logic                          gen_ok;
    logic                          gen_req;
    itp_pkg::t_out_item            gen_item;
    logic                          pop_req;
    logic                          push_req;
    logic                          mv;
    logic                          mv_last;
    logic                          bad_token;

    itp_ram #(
        .WIDTH (itp_pkg::ENTRY_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (cur_entry),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign can_emit  = !r_ov || !i_out_stall;
    assign gen_ok    = !r_hold_v || can_emit;
    assign mem_waddr = r_count[AW-1:0];
    assign mem_raddr = AW'(r_count - CW'(2));

    always_comb begin
        unique case (r_act)
            itp_pkg::ACT_OPERATOR: cur_entry = {itp_pkg::ENT_OP, r_code};
            itp_pkg::ACT_FUNCTION: cur_entry = {itp_pkg::ENT_FUNC, r_code};
            default:               cur_entry = {itp_pkg::ENT_PAREN, 4'd0};
        endcase
    end

    assign bad_token = (r_act > itp_pkg::ACT_END)
        || (r_act == itp_pkg::ACT_OPERATOR && r_code > itp_pkg::OP_MAX)
        || (r_act == itp_pkg::ACT_FUNCTION && r_code > itp_pkg::FUNC_MAX);

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_act    = r_act;
        n_code   = r_code;
        n_word   = r_word;
        n_count  = r_count;
        n_top    = r_top;
        n_endflt = r_endflt;
        n_hold_v = r_hold_v;
        n_hold   = r_hold;
        n_out    = r_out;
        n_ov     = r_ov && i_out_stall;
        gen_req  = 1'b0;
        gen_item = itp_pkg::marker_item(itp_pkg::KIND_OPERAND, itp_pkg::FAULT_NONE);
        pop_req  = 1'b0;
        push_req = 1'b0;
        mv       = 1'b0;
        mv_last  = 1'b0;
        mem_we   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_act    = i_in_data.action;
                    n_code   = i_in_data.code;
                    n_word   = i_in_data.operand_word;
                    n_phase  = PH_SEARCH;
                    n_endflt = itp_pkg::FAULT_NONE;
                    n_state  = S_WORK;
                end
            end
            S_WORK: begin
                if (bad_token) begin
                    n_state = S_FIN;
                end else begin
                    unique case (r_act)
                        itp_pkg::ACT_OPERAND: begin
                            if (gen_ok) begin
                                gen_req = 1'b1;
                                gen_item.out_operand = r_word;
                                n_state = S_FIN;
                            end
                        end
                        itp_pkg::ACT_OPERATOR: begin
                            if (r_code != itp_pkg::OP_POW && r_count != '0
                                    && itp_pkg::prec_of(r_top) >= itp_pkg::prec_of(cur_entry)) begin
                                if (gen_ok) begin
                                    gen_req  = 1'b1;
                                    gen_item = itp_pkg::entry_item(r_top);
                                    pop_req  = 1'b1;
                                end
                            end else begin
                                push_req = 1'b1;
                            end
                        end
                        itp_pkg::ACT_FUNCTION, itp_pkg::ACT_OPEN: begin
                            push_req = 1'b1;
                        end
                        itp_pkg::ACT_CLOSE: begin
                            unique case (r_phase)
                                PH_SEARCH: begin
                                    if (r_count == '0) begin
                                        if (gen_ok) begin
                                            gen_req  = 1'b1;
                                            gen_item = itp_pkg::marker_item(
                                                itp_pkg::KIND_OPERAND, itp_pkg::FAULT_CLOSE);
                                            n_state  = S_FIN;
                                        end
                                    end else if (r_top[5:4] == itp_pkg::ENT_PAREN) begin
                                        pop_req = 1'b1;
                                        n_phase = PH_CHECK;
                                    end else if (gen_ok) begin
                                        gen_req  = 1'b1;
                                        gen_item = itp_pkg::entry_item(r_top);
                                        pop_req  = 1'b1;
                                    end
                                end
                                PH_CHECK: begin
                                    if (r_count != '0 && r_top[5:4] == itp_pkg::ENT_FUNC) begin
                                        if (gen_ok) begin
                                            gen_req  = 1'b1;
                                            gen_item = itp_pkg::entry_item(r_top);
                                            pop_req  = 1'b1;
                                            n_phase  = PH_DONE;
                                        end
                                    end else begin
                                        n_state = S_FIN;
                                    end
                                end
                                default: begin
                                    n_state = S_FIN;
                                end
                            endcase
                        end
                        itp_pkg::ACT_END: begin
                            if (r_count == '0) begin
                                if (gen_ok) begin
                                    gen_req  = 1'b1;
                                    gen_item = itp_pkg::marker_item(itp_pkg::KIND_END, r_endflt);
                                    n_state  = S_FIN;
                                end
                            end else if (r_top[5:4] == itp_pkg::ENT_PAREN) begin
                                pop_req  = 1'b1;
                                n_endflt = itp_pkg::FAULT_OPEN;
                            end else if (gen_ok) begin
                                gen_req  = 1'b1;
                                gen_item = itp_pkg::entry_item(r_top);
                                pop_req  = 1'b1;
                            end
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_LOAD: begin
                n_top   = mem_rdata;
                n_state = S_WORK;
            end
            S_FIN: begin
                if (!r_hold_v) begin
                    n_state = S_IDLE;
                end else if (can_emit) begin
                    mv       = 1'b1;
                    mv_last  = 1'b1;
                    n_hold_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (push_req) begin
            if (r_count >= CW'(STACK_DEPTH)) begin
                if (gen_ok) begin
                    gen_req  = 1'b1;
                    gen_item = itp_pkg::marker_item(itp_pkg::KIND_OPERAND,
                                                    itp_pkg::FAULT_OVERFLOW);
                    n_state  = S_FIN;
                end
            end else begin
                mem_we  = 1'b1;
                n_top   = cur_entry;
                n_count = r_count + CW'(1);
                n_state = S_FIN;
            end
        end

        if (pop_req) begin
            n_count = r_count - CW'(1);
            n_state = S_LOAD;
        end

        if (gen_req) begin
            mv       = r_hold_v;
            n_hold   = gen_item;
            n_hold_v = 1'b1;
        end

        if (mv) begin
            n_out      = r_hold;
            n_out.last = mv_last;
            n_ov       = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act  <= n_act;
        r_code <= n_code;
        r_word <= n_word;
        r_top  <= n_top;
        r_hold <= n_hold;
        r_out  <= n_out;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_SEARCH;
            r_count  <= '0;
            r_endflt <= itp_pkg::FAULT_NONE;
            r_hold_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_endflt <= n_endflt;
            r_hold_v <= n_hold_v;
            r_ov     <= n_ov;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count above depth");

    a_idle_hold_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !r_hold_v)
        else $error("token accepted while a result is still held");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.out_kind == itp_pkg::KIND_END) |-> o_out_data.last)
        else $error("end marker without last flag");

    a_fault_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.fault != itp_pkg::FAULT_NONE) |-> o_out_data.last)
        else $error("fault result without last flag");

endmodule
